@@ rtl/slx_pkg.sv @@
// Shared constants, types and character helpers for the stack language lexer.
package slx_pkg;

  localparam int MAX_TOKEN_CHARS = 8;
  localparam int BUF_DEPTH = 8;
  localparam int BUF_IDX_W = $clog2(BUF_DEPTH);
  localparam int CNT_W = $clog2(BUF_DEPTH + 1);
  localparam int TEXT_W = 8 * BUF_DEPTH;
  localparam int NUM_KEYWORDS = 22;
  localparam int KW_IDX_W = $clog2(NUM_KEYWORDS);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [4:0] KIND_LITERAL = 5'd0;
  localparam logic [4:0] KIND_ARG = 5'd1;
  localparam logic [4:0] KIND_KEYWORD_BASE = 5'd2;
  localparam logic [4:0] KIND_IDENT = 5'd24;
  localparam logic [4:0] KIND_MALFORMED = 5'd25;
  localparam logic [4:0] KIND_END = 5'd26;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_X = 8'h78;
  localparam logic [7:0] CH_A = 8'h61;
  localparam logic [7:0] CH_R = 8'h72;
  localparam logic [7:0] CH_G = 8'h67;

  // Token state as the scanner holds it.
  typedef struct packed {
    logic [TEXT_W-1:0] text;
    logic [CNT_W-1:0]  count;
    logic              overflowed;
    logic [31:0]       acc;
  } slx_token_t;

  // What one accepted word produces.
  typedef struct packed {
    logic token;
    logic token_last;
    logic end_mark;
  } slx_emit_t;

  typedef struct packed {
    logic [4:0]        kind;
    logic [31:0]       lit;
    logic [7:0]        argn;
    logic [3:0]        len;
    logic [TEXT_W-1:0] text;
    logic              last;
  } slx_result_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  // Non-hex characters give zero; such a token is reported malformed anyway.
  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [3:0] v;
    if (is_digit(c)) begin
      v = c[3:0];
    end else if (is_hex(c)) begin
      v = c[3:0] + 4'd9;
    end else begin
      v = 4'd0;
    end
    return v;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

  function automatic logic [CNT_W-1:0] kw_len(input logic [KW_IDX_W-1:0] k);
    logic [CNT_W-1:0] l;
    unique case (k)
      5'd0: l = CNT_W'(5);
      5'd1: l = CNT_W'(6);
      5'd2, 5'd3, 5'd4, 5'd5, 5'd6: l = CNT_W'(1);
      5'd7, 5'd9, 5'd19, 5'd21: l = CNT_W'(3);
      5'd16, 5'd18, 5'd20: l = CNT_W'(4);
      5'd17: l = CNT_W'(5);
      default: l = CNT_W'(2);
    endcase
    return l;
  endfunction

  // String literals are written reversed so the first character lands in the low byte.
  function automatic logic [TEXT_W-1:0] kw_text(input logic [KW_IDX_W-1:0] k);
    logic [TEXT_W-1:0] t;
    unique case (k)
      5'd0:  t = TEXT_W'("nufed");
      5'd1:  t = TEXT_W'("nruter");
      5'd2:  t = TEXT_W'("+");
      5'd3:  t = TEXT_W'("-");
      5'd4:  t = TEXT_W'("*");
      5'd5:  t = TEXT_W'("/");
      5'd6:  t = TEXT_W'("%");
      5'd7:  t = TEXT_W'("dna");
      5'd8:  t = TEXT_W'("ro");
      5'd9:  t = TEXT_W'("ton");
      5'd10: t = TEXT_W'("tl");
      5'd11: t = TEXT_W'("el");
      5'd12: t = TEXT_W'("qe");
      5'd13: t = TEXT_W'("eg");
      5'd14: t = TEXT_W'("tg");
      5'd15: t = TEXT_W'("fi");
      5'd16: t = TEXT_W'("esle");
      5'd17: t = TEXT_W'("fidne");
      5'd18: t = TEXT_W'("pord");
      5'd19: t = TEXT_W'("pud");
      5'd20: t = TEXT_W'("paws");
      5'd21: t = TEXT_W'("tor");
      default: t = '1;
    endcase
    return t;
  endfunction

endpackage

@@ rtl/stack_language_lexer.sv @@
// Stack language lexer: byte-serial tokenizer with classified token output.
//
// Input channel (in_valid/in_ready): one source byte per word in char_byte, or
// end_of_stream high to mark the end of input. Blanks separate tokens, and a
// ';' between tokens starts a comment up to the next line feed.
// Output channel (out_valid/out_ready): one classified token per word, with
// last_result high on the final result caused by an input word. A blank after
// a token gives one result; the end marker gives the pending token, if any,
// and then an end result.
// A result is visible on the output in the cycle after the input word that
// closes the token is accepted. One byte is taken per cycle; the limit is
// the four-entry result queue, which takes a new word whenever it has room for
// two results. With the receiver always ready it never holds more than two,
// so only a stalled receiver slows the input.
// When the receiver stalls, the queue fills and in_ready drops until it drains.
// Reset clears the token, comment and queue state; no result is pending after
// reset and in_ready is high in the first cycle after it.
module stack_language_lexer import slx_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         char_byte,
  input  logic               end_of_stream,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [4:0]         token_kind,
  output logic signed [31:0] token_value,
  output logic [7:0]         arg_number,
  output logic [3:0]         token_length,
  output logic [63:0]        token_text,
  output logic               last_result
);

  logic accept;
  slx_token_t token;
  slx_emit_t emit;
  slx_result_t tok_res, end_res, wr0, q_out;
  logic wr0_en, wr1_en;

  assign accept = in_valid && in_ready;

  slx_scan u_scan (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .char_byte    (char_byte),
    .end_of_stream(end_of_stream),
    .token        (token),
    .emit         (emit)
  );

  slx_classify u_classify (
    .token (token),
    .result(tok_res)
  );

  always_comb begin
    end_res = '0;
    end_res.kind = KIND_END;
    end_res.last = 1'b1;
    wr0 = end_res;
    if (emit.token) begin
      wr0 = tok_res;
      wr0.last = emit.token_last;
    end
  end

  assign wr0_en = emit.token || emit.end_mark;
  assign wr1_en = emit.token && emit.end_mark;

  slx_outq u_outq (
    .clk     (clk),
    .rst     (rst),
    .wr0_en  (wr0_en),
    .wr0     (wr0),
    .wr1_en  (wr1_en),
    .wr1     (end_res),
    .rd_en   (out_valid && out_ready),
    .room    (in_ready),
    .rd_valid(out_valid),
    .rd_data (q_out)
  );

  assign token_kind = q_out.kind;
  assign token_value = $signed(q_out.lit);
  assign arg_number = q_out.argn;
  assign token_length = q_out.len;
  assign token_text = q_out.text;
  assign last_result = q_out.last;

  a_end_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && end_of_stream |=> out_valid)
    else $error("end marker accepted but no result queued");

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (token_kind == KIND_END) |-> last_result)
    else $error("end result without last_result");

  a_literal_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && (token_kind != KIND_LITERAL) |-> (token_value == 0))
    else $error("literal value on a non-literal token");

  a_length_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (token_length <= 4'(MAX_TOKEN_CHARS)))
    else $error("token length beyond buffer");

endmodule

@@ rtl/slx_scan.sv @@
// Character scanner: token buffer, comment tracking and incremental literal value.
module slx_scan import slx_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] char_byte,
  input  logic       end_of_stream,
  output slx_token_t token,
  output slx_emit_t  emit
);

  logic [BUF_DEPTH-1:0][7:0] text_buf;
  logic [CNT_W-1:0] text_count, text_count_next;
  logic in_comment, in_comment_next;
  logic overflowed, overflowed_next;
  logic [31:0] acc, acc_next;
  logic buf_wr;
  logic pending, hex_body;

  assign pending = (text_count != '0) || overflowed;
  assign hex_body = (text_count >= CNT_W'(2)) && (text_buf[0] == CH_ZERO) &&
                    (text_buf[1] == CH_X);

  always_comb begin
    text_count_next = text_count;
    in_comment_next = in_comment;
    overflowed_next = overflowed;
    acc_next = acc;
    buf_wr = 1'b0;
    emit = '0;
    if (accept) begin
      if (end_of_stream) begin
        emit.token = pending && !in_comment;
        emit.end_mark = 1'b1;
        in_comment_next = 1'b0;
        text_count_next = '0;
        overflowed_next = 1'b0;
        acc_next = '0;
      end else if (in_comment) begin
        if (char_byte == CH_LF) begin
          in_comment_next = 1'b0;
        end
      end else if (is_blank(char_byte)) begin
        if (pending) begin
          emit.token = 1'b1;
          emit.token_last = 1'b1;
          text_count_next = '0;
          overflowed_next = 1'b0;
          acc_next = '0;
        end
      end else if ((char_byte == CH_SEMI) && !pending) begin
        in_comment_next = 1'b1;
      end else if (text_count < CNT_W'(MAX_TOKEN_CHARS)) begin
        if (hex_body) begin
          acc_next = {acc[27:0], hex_nibble(char_byte)};
        end else if (is_digit(char_byte)) begin
          acc_next = (acc << 3) + (acc << 1) + {28'd0, char_byte[3:0]};
        end
        buf_wr = 1'b1;
        text_count_next = text_count + CNT_W'(1);
      end else begin
        overflowed_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_count <= '0;
      in_comment <= 1'b0;
      overflowed <= 1'b0;
      acc <= '0;
    end else begin
      text_count <= text_count_next;
      in_comment <= in_comment_next;
      overflowed <= overflowed_next;
      acc <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (buf_wr) begin
      text_buf[text_count[BUF_IDX_W-1:0]] <= char_byte;
    end
  end

  assign token.text = text_buf;
  assign token.count = text_count;
  assign token.overflowed = overflowed;
  assign token.acc = acc;

endmodule

@@ rtl/slx_classify.sv @@
// Token classifier: literal, argN, keyword, identifier or malformed.
module slx_classify import slx_pkg::*; (
  input  slx_token_t  token,
  output slx_result_t result
);

  logic [BUF_DEPTH-1:0] keep, dig_ok, hex_ok, id_ok;
  logic [TEXT_W-1:0] text;
  logic [7:0] b0, b1;
  logic kw_hit;
  logic [KW_IDX_W-1:0] kw_idx;
  logic starts_hex, starts_dec, starts_arg;

  // Bytes at or past the count are stale and read as zero; checks treat them as passing.
  always_comb begin
    for (int i = 0; i < BUF_DEPTH; i++) begin
      keep[i] = CNT_W'(i) < token.count;
      text[8*i +: 8] = keep[i] ? token.text[8*i +: 8] : 8'h00;
      dig_ok[i] = !keep[i] || is_digit(token.text[8*i +: 8]);
      hex_ok[i] = !keep[i] || is_hex(token.text[8*i +: 8]);
      id_ok[i] = !keep[i] || is_digit(token.text[8*i +: 8]) ||
                 is_alpha(token.text[8*i +: 8]) || (token.text[8*i +: 8] == CH_UNDERSCORE);
    end
  end

  always_comb begin
    kw_hit = 1'b0;
    kw_idx = '0;
    for (int k = 0; k < NUM_KEYWORDS; k++) begin
      if ((kw_len(KW_IDX_W'(k)) == token.count) && (kw_text(KW_IDX_W'(k)) == text)) begin
        kw_hit = 1'b1;
        kw_idx = KW_IDX_W'(k);
      end
    end
  end

  assign b0 = token.text[7:0];
  assign b1 = token.text[15:8];
  assign starts_hex = (token.count >= CNT_W'(2)) && (b0 == CH_ZERO) && (b1 == CH_X);
  assign starts_dec = ((token.count >= CNT_W'(1)) && is_digit(b0)) ||
                      ((token.count >= CNT_W'(2)) && (b0 == CH_MINUS) && is_digit(b1));
  assign starts_arg = (token.count >= CNT_W'(4)) && (b0 == CH_A) && (b1 == CH_R) &&
                      (token.text[23:16] == CH_G) && (&dig_ok[BUF_DEPTH-1:3]);

  always_comb begin
    result = '0;
    result.len = 4'(token.count);
    result.text = text;
    result.kind = KIND_MALFORMED;
    if (token.overflowed) begin
      result.kind = KIND_MALFORMED;
    end else if (starts_hex) begin
      if ((token.count > CNT_W'(2)) && (&hex_ok[BUF_DEPTH-1:2])) begin
        result.kind = KIND_LITERAL;
        result.lit = token.acc;
      end
    end else if (starts_dec) begin
      if (&dig_ok[BUF_DEPTH-1:1]) begin
        result.kind = KIND_LITERAL;
        result.lit = (b0 == CH_MINUS) ? (32'd0 - token.acc) : token.acc;
      end
    end else if (starts_arg) begin
      result.kind = KIND_ARG;
      result.argn = (|token.acc[31:8]) ? 8'hFF : token.acc[7:0];
    end else if (kw_hit) begin
      result.kind = KIND_KEYWORD_BASE + 5'(kw_idx);
    end else if ((token.count != '0) && (&id_ok)) begin
      result.kind = KIND_IDENT;
    end
  end

endmodule

@@ rtl/slx_outq.sv @@
// Four-entry result queue that takes up to two results a cycle and delivers one.
module slx_outq import slx_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr0_en,
  input  slx_result_t wr0,
  input  logic        wr1_en,
  input  slx_result_t wr1,
  input  logic        rd_en,
  output logic        room,
  output logic        rd_valid,
  output slx_result_t rd_data
);

  slx_result_t entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic [QPTR_W-1:0] wr_ptr_next1;

  assign wr_ptr_next1 = wr_ptr + QPTR_W'(1);
  // Room for the worst case of two results from one word.
  assign room = count <= QCNT_W'(QUEUE_DEPTH - 2);
  assign rd_valid = count != '0;
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(wr0_en) + QPTR_W'(wr1_en);
      rd_ptr <= rd_ptr + QPTR_W'(rd_en);
      count <= count + QCNT_W'(wr0_en) + QCNT_W'(wr1_en) - QCNT_W'(rd_en);
    end
  end

  always_ff @(posedge clk) begin
    if (wr0_en) begin
      entries[wr_ptr] <= wr0;
    end
    if (wr1_en) begin
      entries[wr_ptr_next1] <= wr1;
    end
  end

endmodule
